// ----- hw/rtl/tccw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Screen geometry, field widths, op codes, character codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_SPACES  = 4;
  localparam int TOTAL_CELLS = COLUMNS * ROWS;

  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = 16;
  localparam int IDX_W      = $clog2(TOTAL_CELLS);
  localparam int TAB_W      = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CHAR_W-1:0]  CH_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0]  CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'd32;

  localparam logic [COLOR_W-1:0] FORE_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 3'd0,
    OP_ERASE = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORE_COLOR = 1'd0,
    REG_BACK_COLOR = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TAB,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;        // latch the input item
    logic put_cell;       // write a cell at the cursor and advance
    logic put_space;      // the cell written is a space, not the item character
    logic erase;          // step back and write code 0
    logic newline;        // go to column 0 of the next row
    logic move;           // set cursor to the clamped target
    logic sweep_init;     // home cursor, arm the clearing sweep
    logic fill_from_item; // sweep uses the item colours, not the registers
    logic sweep_step;     // write one cell of the sweep
    logic read_issue;     // read the target cell
    logic load_out;       // load the result register
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_tab;
    logic            is_newline;
    logic            is_printable;
    logic            at_end;
    logic            at_home;
    logic            last_row;
    logic            sweep_last;
    logic            tab_last;
    logic            out_free;
  } status_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0]  ch,
                                                  input logic [COLOR_W-1:0] fore,
                                                  input logic [COLOR_W-1:0] back);
    make_cell = {back, fore, ch};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tccw_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_req_if: request channel
// Valid/ready channel carrying one console operation.
// ----------------------------------------------------------------------------
interface tccw_req_if;
  logic                           valid;
  logic                           ready;
  logic [tccw_pkg::OP_W-1:0]      op;
  logic [tccw_pkg::CHAR_W-1:0]    char_code;
  logic [tccw_pkg::COL_W-1:0]     column;
  logic [tccw_pkg::ROW_W-1:0]     row;
  logic [tccw_pkg::COLOR_W-1:0]   fill_fore;
  logic [tccw_pkg::COLOR_W-1:0]   fill_back;

  modport source (output valid, op, char_code, column, row, fill_fore, fill_back,
                  input ready);
  modport sink   (input valid, op, char_code, column, row, fill_fore, fill_back,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tccw_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_res_if: result channel
// Valid/ready channel carrying the cursor and cell word after one operation.
// ----------------------------------------------------------------------------
interface tccw_res_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::COL_W-1:0]    cursor_column;
  logic [tccw_pkg::ROW_W-1:0]    cursor_row;
  logic [tccw_pkg::CELL_W-1:0]   cell_data;
  logic                          screen_wiped;

  modport source (output valid, cursor_column, cursor_row, cell_data, screen_wiped,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_row, cell_data, screen_wiped,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tccw_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_controller: operation sequencer
// Decodes the latched item and steps the datapath through cell writes,
// the clearing sweep, cell reads and the result load.
// ----------------------------------------------------------------------------
module tccw_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccw_pkg::status_t status,
  output tccw_pkg::cmd_t    cmd
);
  import tccw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.op)
          OP_PUT: begin
            if (status.is_tab) begin
              state_next = ST_TAB;
            end else if (status.is_newline) begin
              state_next = status.last_row ? ST_SWEEP : ST_DONE;
            end else if (status.is_printable && status.at_end) begin
              state_next = ST_SWEEP;
            end else begin
              state_next = ST_DONE;
            end
          end
          OP_CLEAR: state_next = ST_SWEEP;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_TAB: begin
        if (status.at_end) begin
          state_next = ST_SWEEP;
        end else if (status.tab_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        case (status.op)
          OP_PUT: begin
            if (status.is_tab) begin
              cmd = '0;
            end else if (status.is_newline) begin
              cmd.sweep_init = status.last_row;
              cmd.newline    = !status.last_row;
            end else if (status.is_printable) begin
              cmd.put_cell   = 1'b1;
              cmd.sweep_init = status.at_end;
            end
          end
          OP_ERASE: cmd.erase      = !status.at_home;
          OP_MOVE:  cmd.move       = 1'b1;
          OP_CLEAR: begin
            cmd.sweep_init     = 1'b1;
            cmd.fill_from_item = 1'b1;
          end
          OP_READ:  cmd.read_issue = 1'b1;
          default:  cmd = '0;
        endcase
      end
      ST_TAB: begin
        cmd.put_cell   = 1'b1;
        cmd.put_space  = 1'b1;
        cmd.sweep_init = status.at_end;
      end
      ST_SWEEP: cmd.sweep_step = 1'b1;
      ST_DONE:  cmd.load_out   = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tccw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_datapath: screen store, cursor and result register
// Holds the 2000-cell screen memory, the cursor (index plus column/row),
// colour registers, the sweep and tab counters and the output register.
// ----------------------------------------------------------------------------
module tccw_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  tccw_pkg::cmd_t                  cmd,
  output tccw_pkg::status_t               status,
  input  logic [tccw_pkg::OP_W-1:0]       op,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tccw_pkg::COL_W-1:0]      column,
  input  logic [tccw_pkg::ROW_W-1:0]      row,
  input  logic [tccw_pkg::COLOR_W-1:0]    fill_fore,
  input  logic [tccw_pkg::COLOR_W-1:0]    fill_back,
  input  logic                            cfg_write,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tccw_pkg::COL_W-1:0]      cursor_column,
  output logic [tccw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tccw_pkg::CELL_W-1:0]     cell_data,
  output logic                            screen_wiped
);
  import tccw_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TOTAL_CELLS - 1);

  logic [CELL_W-1:0]  mem [TOTAL_CELLS];

  logic [OP_W-1:0]    op_q;
  logic [CHAR_W-1:0]  char_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [COLOR_W-1:0] fill_fore_q;
  logic [COLOR_W-1:0] fill_back_q;
  logic [COLOR_W-1:0] fg_colour;
  logic [COLOR_W-1:0] bg_colour;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [IDX_W-1:0]   idx;
  logic [TAB_W-1:0]   tab_cnt;
  logic [IDX_W-1:0]   sweep_cnt;
  logic [CELL_W-1:0]  sweep_word;
  logic               wiped;
  logic [CELL_W-1:0]  rdata;

  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   prev_idx;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic [CHAR_W-1:0]  put_char;

  // Item latch, clamped on the way in
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= op;
      char_q      <= char_code;
      col_q       <= (column > COL_MAX) ? COL_MAX : column;
      row_q       <= (row > ROW_MAX) ? ROW_MAX : row;
      fill_fore_q <= fill_fore;
      fill_back_q <= fill_back;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour <= FORE_RESET;
      bg_colour <= BACK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FORE_COLOR: fg_colour <= cfg_data;
        REG_BACK_COLOR: bg_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tgt_idx  = IDX_W'(row_q) * IDX_W'(COLUMNS) + IDX_W'(col_q);
  assign prev_idx = idx - IDX_W'(1);

  // Cursor: linear index kept alongside column and row
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      idx     <= '0;
    end else if (cmd.sweep_init) begin
      cur_col <= '0;
      cur_row <= '0;
      idx     <= '0;
    end else if (cmd.put_cell) begin
      idx <= idx + IDX_W'(1);
      if (cur_col == COL_MAX) begin
        cur_col <= '0;
        cur_row <= cur_row + ROW_W'(1);
      end else begin
        cur_col <= cur_col + COL_W'(1);
      end
    end else if (cmd.erase) begin
      idx <= prev_idx;
      if (cur_col == '0) begin
        cur_col <= COL_MAX;
        cur_row <= cur_row - ROW_W'(1);
      end else begin
        cur_col <= cur_col - COL_W'(1);
      end
    end else if (cmd.newline) begin
      idx     <= idx + IDX_W'(COLUMNS) - IDX_W'(cur_col);
      cur_col <= '0;
      cur_row <= cur_row + ROW_W'(1);
    end else if (cmd.move) begin
      idx     <= tgt_idx;
      cur_col <= col_q;
      cur_row <= row_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tab_cnt <= '0;
    end else if (cmd.put_cell && cmd.put_space) begin
      tab_cnt <= tab_cnt + TAB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      sweep_cnt  <= '0;
      sweep_word <= cmd.fill_from_item ? make_cell(CH_SPACE, fill_fore_q, fill_back_q)
                                       : make_cell(CH_SPACE, fg_colour, bg_colour);
    end else if (cmd.sweep_step) begin
      sweep_cnt <= sweep_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      wiped <= 1'b0;
    end else if (cmd.sweep_init) begin
      wiped <= 1'b1;
    end
  end

  // Single write port shared by cell writes, erase and the sweep
  assign put_char = cmd.put_space ? CH_SPACE : char_q;

  always_comb begin
    wr_en   = cmd.put_cell || cmd.erase || cmd.sweep_step;
    wr_addr = idx;
    wr_data = make_cell(put_char, fg_colour, bg_colour);
    if (cmd.sweep_step) begin
      wr_addr = sweep_cnt;
      wr_data = sweep_word;
    end else if (cmd.erase) begin
      wr_addr = prev_idx;
      wr_data = make_cell(CH_NUL, fg_colour, bg_colour);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_issue) begin
      rdata <= mem[tgt_idx];
    end
  end

  // Result register; a new result may be loaded in the cycle the old one transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_column <= cur_col;
      cursor_row    <= cur_row;
      cell_data     <= (op_q == OP_READ) ? rdata : '0;
      screen_wiped  <= wiped;
    end
  end

  always_comb begin
    status.op           = op_q;
    status.is_tab       = (char_q == CH_TAB);
    status.is_newline   = (char_q == CH_NEWLINE);
    status.is_printable = (char_q != CH_NUL) && !char_q[CHAR_W-1] &&
                          (char_q != CH_TAB) && (char_q != CH_NEWLINE);
    status.at_end       = (idx == IDX_MAX);
    status.at_home      = (idx == '0);
    status.last_row     = (cur_row == ROW_MAX);
    status.sweep_last   = (sweep_cnt == IDX_MAX);
    status.tab_last     = (tab_cnt == TAB_W'(TAB_SPACES - 1));
    status.out_free     = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put_cell, cmd.erase, cmd.sweep_step}))
    else $error("more than one source drives the cell write port");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_MAX)
    else $error("write index beyond the last cell");

  a_idx_matches: assert property (@(posedge clk) disable iff (rst)
    idx == IDX_W'(cur_row) * IDX_W'(COLUMNS) + IDX_W'(cur_col))
    else $error("write index and column/row disagree");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_cell_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer: 80x25 text-mode screen store
// Character cell writer with cursor, erase, move, clear and cell read.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the next is accepted while the previous
// result still waits in the output register. Move, read, erase, newline,
// ignored codes and printable characters are done in the decode state before
// the result load; a tab writes up to TAB_SPACES spaces in the tab state (one
// memory write per cell, on the single write port). A clear, a newline on the
// last row, or a write past the last cell sweeps all 2000 cells one per cycle.
// Cells hold ((back << 4) | fore) << 8 | char; cells never written read back
// undefined (there is no clearing pass after reset).
module text_console_cell_writer (
  input  logic                            clk,
  input  logic                            rst,
  tccw_req_if.sink                        request,
  tccw_res_if.source                      result,
  input  logic                            cfg_write,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tccw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tccw_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (request.op),
    .char_code     (request.char_code),
    .column        (request.column),
    .row           (request.row),
    .fill_fore     (request.fill_fore),
    .fill_back     (request.fill_back),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .cursor_column (result.cursor_column),
    .cursor_row    (result.cursor_row),
    .cell_data     (result.cell_data),
    .screen_wiped  (result.screen_wiped)
  );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_console_cell_writer
// Drives console operations over the request channel and compares every
// result transfer with a behavioural screen model updated at each request
// transfer. The colour registers change between phases. Both channels idle in
// short random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // must outlast a full sweep of all cells
  localparam int PHASE_OPS   = 200;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_code;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] fill_fore;
    logic [COLOR_W-1:0] fill_back;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
    logic              screen_wiped;
  } console_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FORE_COLOR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tccw_req_if req_ch ();
  tccw_res_if res_ch ();

  text_console_cell_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .request   (req_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  console_req_t pending_ops[$];
  console_res_t expected_results[$];
  int           issued = 0;
  int           useful_items = 0;
  int           results_seen = 0;
  int           errors = 0;
  int           quiet_cycles = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  logic         calm = 1'b0;

  // screen model state
  logic [CELL_W-1:0]  screen_model [TOTAL_CELLS];
  int unsigned        cell_pos;
  logic [COLOR_W-1:0] pen_fore;
  logic [COLOR_W-1:0] pen_back;

  function automatic void blank_screen(input logic [COLOR_W-1:0] f,
                                       input logic [COLOR_W-1:0] b);
    int i;
    for (i = 0; i < TOTAL_CELLS; i++) screen_model[i] = {b, f, CH_SPACE};
    cell_pos = 0;
  endfunction

  // writes at the cursor and advances; returns 1 when the write ran off the end
  function automatic logic store_char(input logic [CHAR_W-1:0] ch);
    if (cell_pos >= TOTAL_CELLS) cell_pos = 0;
    screen_model[cell_pos] = {pen_back, pen_fore, ch};
    cell_pos++;
    if (cell_pos >= TOTAL_CELLS) begin
      blank_screen(pen_fore, pen_back);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_res_t predict_console(input console_req_t r);
    console_res_t res;
    int unsigned  col;
    int unsigned  line;
    int           k;
    col  = (r.column > COLUMNS - 1) ? COLUMNS - 1 : r.column;
    line = (r.row > ROWS - 1) ? ROWS - 1 : r.row;
    res  = '0;
    case (r.op)
      OP_PUT: begin
        if (r.char_code == CH_TAB) begin
          // spaces left over after a wipe are dropped
          for (k = 0; k < TAB_SPACES && !res.screen_wiped; k++)
            res.screen_wiped = store_char(CH_SPACE);
        end else if (r.char_code == CH_NEWLINE) begin
          if (cell_pos / COLUMNS >= ROWS - 1) begin
            blank_screen(pen_fore, pen_back);
            res.screen_wiped = 1'b1;
          end else begin
            cell_pos = (cell_pos / COLUMNS + 1) * COLUMNS;
          end
        end else if (r.char_code != CH_NUL && !r.char_code[CHAR_W-1]) begin
          res.screen_wiped = store_char(r.char_code);
        end
      end
      OP_ERASE: begin
        if (cell_pos > 0 && cell_pos <= TOTAL_CELLS) begin
          cell_pos--;
          screen_model[cell_pos] = {pen_back, pen_fore, CH_NUL};
        end
      end
      OP_MOVE: cell_pos = line * COLUMNS + col;
      OP_CLEAR: begin
        blank_screen(r.fill_fore, r.fill_back);
        res.screen_wiped = 1'b1;
      end
      OP_READ: res.cell_data = screen_model[line * COLUMNS + col];
      default: ;
    endcase
    res.cursor_column = COL_W'(cell_pos % COLUMNS);
    res.cursor_row    = ROW_W'(cell_pos / COLUMNS);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(posedge clk) begin : drive_requests
    console_req_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pending_ops.size() > 0) begin
        item = pending_ops.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.op        <= item.op;
        req_ch.char_code <= item.char_code;
        req_ch.column    <= item.column;
        req_ch.row       <= item.row;
        req_ch.fill_fore <= item.fill_fore;
        req_ch.fill_back <= item.fill_back;
        if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 3);
    end
  end

  // predict on request transfer, check on result transfer
  always @(posedge clk) begin : check_results
    console_res_t want;
    console_req_t seen;
    logic         moved;
    if (rst) begin
      cell_pos     = 0;
      pen_fore     = FORE_RESET;
      pen_back     = BACK_RESET;
      quiet_cycles <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FORE_COLOR: pen_fore = cfg_data;
          REG_BACK_COLOR: pen_back = cfg_data;
          default: ;
        endcase
      end
      moved = 1'b0;
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual col %0d row %0d",
                   $time, res_ch.cursor_column, res_ch.cursor_row);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_column", 32'(want.cursor_column), 32'(res_ch.cursor_column));
          check_field("cursor_row", 32'(want.cursor_row), 32'(res_ch.cursor_row));
          check_field("cell_data", 32'(want.cell_data), 32'(res_ch.cell_data));
          check_field("screen_wiped", 32'(want.screen_wiped), 32'(res_ch.screen_wiped));
          results_seen <= results_seen + 1;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        seen.op        = req_ch.op;
        seen.char_code = req_ch.char_code;
        seen.column    = req_ch.column;
        seen.row       = req_ch.row;
        seen.fill_fore = req_ch.fill_fore;
        seen.fill_back = req_ch.fill_back;
        expected_results.push_back(predict_console(seen));
      end
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] line,
                          input logic [COLOR_W-1:0] ff, input logic [COLOR_W-1:0] fb);
    console_req_t r;
    r = '{op, ch, col, line, ff, fb};
    pending_ops.push_back(r);
    issued++;
    if (!(op > OP_READ || (op == OP_PUT && (ch == CH_NUL || ch[CHAR_W-1]))))
      useful_items++;
  endtask

  function automatic logic [COL_W-1:0] rand_column();
    return ($urandom_range(0, 4) == 0) ? COL_W'($urandom_range(COLUMNS, 127))
                                       : COL_W'($urandom_range(0, COLUMNS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ($urandom_range(0, 6) == 0) ? ROW_W'($urandom_range(ROWS, 31))
                                       : ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    case ($urandom_range(0, 9))
      0:       return CH_TAB;
      1:       return CH_NEWLINE;
      2:       return CH_SPACE;
      3:       return $urandom_range(0, 1) ? CH_NUL : CHAR_W'($urandom_range(128, 255));
      default: return CHAR_W'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COLOR_W-1:0] rand_colour();
    return COLOR_W'($urandom_range(0, 15));
  endfunction

  // text typed near the bottom of the screen, so that wraps and wipes happen
  task automatic add_typing_run();
    int n;
    queue_op(OP_MOVE, rand_byte(), rand_column(), ROW_W'($urandom_range(20, 24)),
             rand_colour(), rand_colour());
    n = $urandom_range(8, 40);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: queue_op(OP_ERASE, rand_byte(), rand_column(), rand_row(),
                    rand_colour(), rand_colour());
        1: queue_op(OP_READ, rand_byte(), rand_column(),
                    $urandom_range(0, 1) ? ROW_W'(ROWS - 1) : rand_row(),
                    rand_colour(), rand_colour());
        2: queue_op(OP_PUT, CH_NEWLINE, rand_column(), rand_row(),
                    rand_colour(), rand_colour());
        default: queue_op(OP_PUT, rand_char(), rand_column(), rand_row(),
                          rand_colour(), rand_colour());
      endcase
    end
  endtask

  task automatic add_loose_op();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_PUT;
    else if (pick < 45) op = OP_ERASE;
    else if (pick < 60) op = OP_MOVE;
    else if (pick < 64) op = OP_CLEAR;
    else if (pick < 93) op = OP_READ;
    else                op = OP_W'($urandom_range(5, 7));
    queue_op(op, (op == OP_PUT) ? rand_char() : rand_byte(),
             rand_column(), rand_row(), rand_colour(), rand_colour());
  endtask

  task automatic wait_idle();
    while (results_seen != issued) @(posedge clk);
  endtask

  task automatic set_colours(input logic [COLOR_W-1:0] f, input logic [COLOR_W-1:0] b);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FORE_COLOR;
    cfg_data  <= f;
    @(posedge clk);
    cfg_index <= REG_BACK_COLOR;
    cfg_data  <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0] phase_fore [5];
    logic [COLOR_W-1:0] phase_back [5];
    int p;
    int start;
    phase_fore = '{4'd0, 4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd15};
    phase_back = '{4'd0, 4'd15, 4'd15, 4'($urandom_range(1, 14)), 4'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, colours at their reset values; the screen is defined first
    queue_op(OP_CLEAR, 8'd0, 7'd0, 5'd0, 4'd0, 4'd15);
    queue_op(OP_READ, 8'd0, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, 8'd65, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, 8'd1, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, 8'd127, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_NUL, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, 8'd128, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_TAB, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_SPACE, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_READ, 8'd0, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_ERASE, 8'd0, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_READ, 8'd0, 7'd7, 5'd0, 4'd0, 4'd0);
    queue_op(OP_MOVE, 8'd0, 7'd127, 5'd31, 4'd0, 4'd0);
    queue_op(OP_PUT, 8'd90, 7'd0, 5'd0, 4'd0, 4'd0);      // last cell, runs off the end
    queue_op(OP_ERASE, 8'd0, 7'd0, 5'd0, 4'd0, 4'd0);     // at home: no effect
    queue_op(OP_MOVE, 8'd0, 7'd0, 5'd24, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_NEWLINE, 7'd0, 5'd0, 4'd0, 4'd0); // newline on the last row
    queue_op(OP_MOVE, 8'd0, 7'd5, 5'd3, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_NEWLINE, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_MOVE, 8'd0, 7'd77, 5'd24, 4'd0, 4'd0);
    queue_op(OP_PUT, CH_TAB, 7'd0, 5'd0, 4'd0, 4'd0);     // tab cut short by a wipe
    queue_op(3'd5, 8'd255, 7'd127, 5'd31, 4'd15, 4'd15);
    queue_op(3'd7, 8'd0, 7'd0, 5'd0, 4'd0, 4'd0);
    queue_op(OP_READ, 8'd0, 7'd127, 5'd31, 4'd0, 4'd0);
    queue_op(OP_CLEAR, 8'd0, 7'd0, 5'd0, 4'd15, 4'd15);
    wait_idle();

    for (p = 0; p < 5; p++) begin
      set_colours(phase_fore[p], phase_back[p]);
      calm  = (p == 4);
      start = useful_items;
      while (useful_items - start < PHASE_OPS) begin
        if ($urandom_range(0, 2) != 0) add_typing_run();
        else repeat (5) add_loose_op();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
